>>> src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probe hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_OK      = 2'd0,
    RES_MISSING = 2'd1,
    RES_EXISTS  = 2'd2,
    RES_FULL    = 2'd3
  } res_t;

  localparam logic [1:0] ST_UNUSED = 2'd0;
  localparam logic [1:0] ST_USED   = 2'd1;
  localparam logic [1:0] ST_TOMB   = 2'd2;

  localparam logic CFG_TABLE_SIZE   = 1'b0;
  localparam logic CFG_ALLOW_UPDATE = 1'b1;

endpackage

>>> src/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first port: a write cycle returns the old word, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing key/value table with FNV-1a hashing and linear probing.
// ----------------------------------------------------------------------------
// One operation at a time. An item's key is hashed one byte a cycle,
// with a further step to see the end mark when the key is shorter than
// eight bytes (one 32x32 FNV multiply per cycle), then taken modulo the
// table size by restoring subtraction one bit a cycle, then each probed
// slot is read and checked in turn through the single-port
// status/key/value RAMs (at most PROBE_LIMIT probes), then the result is
// written back; a put into a full table skips the probes. The result is
// presented the cycle after the write back, and the input opens again as
// soon as the result is taken. After reset, and after every clear, the
// status RAM is swept one slot a cycle while no item is taken; a clear
// item's result is given once that sweep is done.
module linear_probe_hash_table_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int PROBE_LIMIT = 8,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] found_value,
  output logic [9:0]  slot,
  output logic [10:0] entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(PROBE_LIMIT + 1);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_WRITE, S_DONE
  } state_t;

  state_t state;
  logic [10:0] table_size;
  logic        allow_update;
  logic [1:0]  op;
  logic [63:0] nkey;
  logic [31:0] val;
  logic [31:0] hash;
  logic [2:0]  byte_idx;
  logic [4:0]  mod_cnt;
  logic [31:0] rem;
  logic [AW-1:0] idx;
  logic [AW:0]   sweep_addr;
  logic [PW-1:0] probes;
  logic        have_free;
  logic [AW-1:0] free_idx;
  logic        have_target;
  logic [AW-1:0] target;
  logic        target_used;
  logic [10:0] used_count;
  logic        clearing;

  // ram ports
  logic          st_we, kv_we;
  logic [AW-1:0] ram_addr;
  logic [1:0]    st_wdata, st_rdata;
  logic [63:0]   key_wdata, key_rdata;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

  // effective size, clamped to 1..TABLE_DEPTH
  logic [16:0] size_eff;
  always_comb begin
    if (table_size == 11'd0) begin
      size_eff = 17'd1;
    end else if (17'(table_size) > 17'(TABLE_DEPTH)) begin
      size_eff = 17'(TABLE_DEPTH);
    end else begin
      size_eff = 17'(table_size);
    end
  end

  // normalize input key: stop at first zero byte, drop bytes past KEY_BYTES
  logic [63:0] in_nkey;
  always_comb begin
    logic stop;
    stop    = 1'b0;
    in_nkey = '0;
    for (int i = 0; i < 8; i++) begin
      if (i >= KEY_BYTES || key[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        in_nkey[8*i +: 8] = key[8*i +: 8];
      end
    end
  end

  logic [7:0]  cur_byte;
  logic [31:0] hash_mul;
  assign cur_byte = nkey[{byte_idx, 3'b000} +: 8];
  assign hash_mul = (hash ^ {24'd0, cur_byte}) * lpht_pkg::FNV_PRIME;

  // restoring division step
  logic [32:0] rem_shift;
  logic [32:0] rem_sub;
  assign rem_shift = {rem, hash[5'd31 - mod_cnt]};
  assign rem_sub   = rem_shift - 33'(size_eff);

  logic [AW-1:0] idx_inc;
  assign idx_inc = (17'(idx) + 17'd1 >= size_eff) ? '0 : idx + AW'(1);

  logic key_hit;
  assign key_hit = (key_rdata == nkey);

  // ram address and write data select
  always_comb begin
    st_we     = 1'b0;
    kv_we     = 1'b0;
    st_wdata  = lpht_pkg::ST_UNUSED;
    key_wdata = nkey;
    val_wdata = VALUE_WIDTH'(val);
    ram_addr  = idx;
    unique case (state)
      S_SWEEP: begin
        st_we    = 1'b1;
        ram_addr = sweep_addr[AW-1:0];
      end
      S_WRITE: begin
        ram_addr = target;
        if (op == lpht_pkg::OP_PUT) begin
          st_we    = have_target && !(target_used && !allow_update);
          kv_we    = st_we;
          st_wdata = lpht_pkg::ST_USED;
        end else if (op == lpht_pkg::OP_REMOVE) begin
          st_we     = have_target;
          kv_we     = have_target;
          st_wdata  = lpht_pkg::ST_TOMB;
          key_wdata = '0;
          val_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  lpht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_status (
    .clk(clk), .we(st_we), .addr(ram_addr), .wdata(st_wdata), .rdata(st_rdata)
  );
  lpht_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_key (
    .clk(clk), .we(kv_we), .addr(ram_addr), .wdata(key_wdata), .rdata(key_rdata)
  );
  lpht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_value (
    .clk(clk), .we(kv_we), .addr(ram_addr), .wdata(val_wdata), .rdata(val_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= 11'd1024;
      allow_update <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpht_pkg::CFG_TABLE_SIZE:   table_size   <= cfg_data;
        lpht_pkg::CFG_ALLOW_UPDATE: allow_update <= cfg_data[0];
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      used_count <= '0;
      out_valid  <= 1'b0;
      clearing   <= 1'b0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          // clear status, one slot a cycle
          if (sweep_addr == (AW+1)'(TABLE_DEPTH - 1)) begin
            sweep_addr <= '0;
            if (clearing) begin
              clearing    <= 1'b0;
              status      <= lpht_pkg::RES_OK;
              found_value <= '0;
              slot        <= '0;
              entry_count <= '0;
              out_valid   <= 1'b1;
              state       <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op          <= operation;
            nkey        <= in_nkey;
            val         <= value;
            hash        <= lpht_pkg::FNV_BASIS;
            byte_idx    <= '0;
            have_free   <= 1'b0;
            have_target <= 1'b0;
            target_used <= 1'b0;
            probes      <= '0;
            if (operation == lpht_pkg::OP_CLEAR) begin
              used_count <= '0;
              clearing   <= 1'b1;
              state      <= S_SWEEP;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          // one byte a cycle until a zero byte or the eighth byte
          if (cur_byte == 8'd0) begin
            rem     <= '0;
            mod_cnt <= '0;
            state   <= S_MOD;
          end else begin
            hash <= hash_mul;
            if (byte_idx == 3'd7) begin
              rem     <= '0;
              mod_cnt <= '0;
              state   <= S_MOD;
            end
            byte_idx <= byte_idx + 1'b1;
          end
        end
        S_MOD: begin
          rem     <= rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == 5'd31) begin
            idx <= rem_sub[32] ? rem_shift[AW-1:0] : rem_sub[AW-1:0];
            if (op == lpht_pkg::OP_PUT && 17'(used_count) >= size_eff) begin
              state <= S_WRITE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // address presented; data next cycle
          state <= S_CHECK;
        end
        S_CHECK: begin
          priority if (st_rdata == lpht_pkg::ST_UNUSED) begin
            if (op == lpht_pkg::OP_PUT) begin
              have_target <= 1'b1;
              target      <= have_free ? free_idx : idx;
            end
            state <= S_WRITE;
          end else if (st_rdata == lpht_pkg::ST_USED && key_hit) begin
            have_target <= 1'b1;
            target      <= idx;
            target_used <= 1'b1;
            found_value <= 32'(val_rdata);
            state       <= S_WRITE;
          end else begin
            if (st_rdata == lpht_pkg::ST_TOMB && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= idx;
            end
            idx    <= idx_inc;
            probes <= probes + 1'b1;
            if (probes == PW'(PROBE_LIMIT - 1)) begin
              if (op == lpht_pkg::OP_PUT) begin
                if (have_free) begin
                  have_target <= 1'b1;
                  target      <= free_idx;
                end else if (st_rdata == lpht_pkg::ST_TOMB) begin
                  have_target <= 1'b1;
                  target      <= idx;
                end
              end
              state <= S_WRITE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_WRITE: begin
          // build the result; a successful get keeps its captured value
          slot <= have_target ? 10'(target) : 10'd0;
          if (op != lpht_pkg::OP_GET || !have_target) begin
            found_value <= '0;
          end
          unique case (op)
            lpht_pkg::OP_PUT: begin
              if (!have_target) begin
                status      <= lpht_pkg::RES_FULL;
                entry_count <= used_count;
              end else if (target_used && !allow_update) begin
                status      <= lpht_pkg::RES_EXISTS;
                entry_count <= used_count;
              end else begin
                status <= lpht_pkg::RES_OK;
                if (!target_used) begin
                  used_count  <= used_count + 1'b1;
                  entry_count <= used_count + 1'b1;
                end else begin
                  entry_count <= used_count;
                end
              end
            end
            lpht_pkg::OP_GET: begin
              status      <= have_target ? lpht_pkg::RES_OK : lpht_pkg::RES_MISSING;
              entry_count <= used_count;
            end
            default: begin
              status <= have_target ? lpht_pkg::RES_OK : lpht_pkg::RES_MISSING;
              if (have_target && used_count != 11'd0) begin
                used_count  <= used_count - 1'b1;
                entry_count <= used_count - 1'b1;
              end else begin
                entry_count <= used_count;
              end
            end
          endcase
          out_valid <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the linear probe hash table unit: directed puts, gets, removes and
// clears around collisions, tombstones, full and barred updates, then random
// traffic on small key sets, compared against an in-bench table model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH = 1024;
  localparam int PROBES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [63:0] key = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] found_value;
  logic [9:0]  slot;
  logic [10:0] entry_count;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [9:0]  slot;
    logic [10:0] entry_count;
  } result_t;

  // Table model
  logic [1:0]  mdl_state [DEPTH];
  logic [63:0] mdl_key [DEPTH];
  logic [31:0] mdl_value [DEPTH];
  int unsigned mdl_used;
  logic [10:0] mdl_size;
  logic        mdl_allow;

  result_t expected_q[$];
  int          mismatches = 0;
  bit          hold_off = 1'b0;
  bit          quiet_stall = 1'b0;
  logic [63:0] key_pool [16];

  linear_probe_hash_table_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .key(key), .value(value), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .found_value(found_value),
    .slot(slot), .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] trim_key(logic [63:0] k);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) break;
      r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] fnv1a(logic [63:0] k);
    logic [31:0] h;
    h = lpht_pkg::FNV_BASIS;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'd0) break;
      h = (h ^ {24'd0, k[8*i +: 8]}) * lpht_pkg::FNV_PRIME;
    end
    return h;
  endfunction

  // Apply one operation to the model and return its result
  function automatic result_t table_apply(lpht_pkg::op_t op, logic [63:0] raw_key,
                                          logic [31:0] val);
    result_t r;
    logic [63:0] k;
    int unsigned sz, idx, free_idx, target;
    bit have_free, have_target;
    k = trim_key(raw_key);
    sz = (mdl_size == 0) ? 1 : (mdl_size > DEPTH) ? DEPTH : mdl_size;
    idx = fnv1a(k) % sz;
    r = '0;
    have_free = 0;
    have_target = 0;
    free_idx = 0;
    target = 0;
    case (op)
      lpht_pkg::OP_PUT: begin
        if (mdl_used >= sz) begin
          r.status = lpht_pkg::RES_FULL;
        end else begin
          for (int i = 0; i < PROBES; i++) begin
            if (mdl_state[idx] == lpht_pkg::ST_UNUSED) begin
              target = have_free ? free_idx : idx;
              have_target = 1;
              break;
            end
            if (mdl_state[idx] == lpht_pkg::ST_TOMB) begin
              if (!have_free) begin
                have_free = 1;
                free_idx = idx;
              end
            end else if (mdl_key[idx] == k) begin
              target = idx;
              have_target = 1;
              break;
            end
            idx = (idx + 1) % sz;
          end
          if (!have_target && have_free) begin
            target = free_idx;
            have_target = 1;
          end
          if (!have_target) begin
            r.status = lpht_pkg::RES_FULL;
          end else if (mdl_state[target] == lpht_pkg::ST_USED && !mdl_allow) begin
            r.status = lpht_pkg::RES_EXISTS;
            r.slot = target[9:0];
          end else begin
            if (mdl_state[target] != lpht_pkg::ST_USED) mdl_used++;
            mdl_state[target] = lpht_pkg::ST_USED;
            mdl_key[target] = k;
            mdl_value[target] = val;
            r.slot = target[9:0];
          end
        end
      end
      lpht_pkg::OP_GET, lpht_pkg::OP_REMOVE: begin
        r.status = lpht_pkg::RES_MISSING;
        for (int i = 0; i < PROBES; i++) begin
          if (mdl_state[idx] == lpht_pkg::ST_UNUSED) break;
          if (mdl_state[idx] == lpht_pkg::ST_USED && mdl_key[idx] == k) begin
            r.status = lpht_pkg::RES_OK;
            r.slot = idx[9:0];
            if (op == lpht_pkg::OP_GET) begin
              r.found_value = mdl_value[idx];
            end else begin
              if (mdl_used > 0) mdl_used--;
              mdl_state[idx] = lpht_pkg::ST_TOMB;
            end
            break;
          end
          idx = (idx + 1) % sz;
        end
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) mdl_state[i] = lpht_pkg::ST_UNUSED;
        mdl_used = 0;
      end
    endcase
    r.entry_count = mdl_used[10:0];
    return r;
  endfunction

  // Send one item; sender idles at random unless quiet
  task automatic send_item(lpht_pkg::op_t op, logic [63:0] k, logic [31:0] v);
    while (!quiet_stall && $urandom_range(99) < 11) @(posedge clk);
    in_valid <= 1'b1;
    operation <= op;
    key <= k;
    value <= v;
    expected_q.push_back(table_apply(op, k, v));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    // drop valid for a cycle; the unit is busy with this item anyway
    @(posedge clk);
  endtask

  // Wait for the table to drain, then write a register
  task automatic write_reg(logic idx, logic [10:0] data);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lpht_pkg::CFG_TABLE_SIZE) mdl_size = data;
    else mdl_allow = data[0];
  endtask

  // Receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || (!quiet_stall && $urandom_range(99) < 11);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result status=%0d slot=%0d", status, slot);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.status != status || exp_r.found_value != found_value ||
            exp_r.slot != slot || exp_r.entry_count != entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d val=%h slot=%0d cnt=%0d,",
                      " got st=%0d val=%h slot=%0d cnt=%0d"},
                     exp_r.status, exp_r.found_value, exp_r.slot, exp_r.entry_count,
                     status, found_value, slot, entry_count);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(lpht_pkg::OP_GET, 64'h0, 32'h0);
    send_item(lpht_pkg::OP_PUT, 64'h0, 32'hFFFF_FFFF);
    send_item(lpht_pkg::OP_GET, 64'h0, 32'h0);
    send_item(lpht_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A);
    send_item(lpht_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    // bytes after the end mark are ignored
    send_item(lpht_pkg::OP_PUT, 64'h1234_0000_0041, 32'h1);
    send_item(lpht_pkg::OP_GET, 64'h41, 32'h0);
    send_item(lpht_pkg::OP_PUT, 64'h41, 32'h2);
    send_item(lpht_pkg::OP_REMOVE, 64'h41, 32'h0);
    send_item(lpht_pkg::OP_REMOVE, 64'h41, 32'h0);
    send_item(lpht_pkg::OP_GET, 64'h41, 32'h0);
    send_item(lpht_pkg::OP_CLEAR, 64'hDEAD, 32'h0);
    send_item(lpht_pkg::OP_GET, 64'h0, 32'h0);
  endtask

  // Set table size and update rule: collisions, wrap, tombstones, full, barred update
  task automatic test_small_table(logic [10:0] sz, bit allow, int n);
    write_reg(lpht_pkg::CFG_TABLE_SIZE, sz);
    write_reg(lpht_pkg::CFG_ALLOW_UPDATE, {10'd0, allow});
    send_item(lpht_pkg::OP_CLEAR, 64'h0, 32'h0);
    for (int i = 0; i < n; i++)
      send_item(lpht_pkg::op_t'($urandom_range(3) == 0 ? $urandom_range(2) : 0),
                key_pool[$urandom_range(15)], $urandom);
  endtask

  task automatic test_random(int n);
    logic [63:0] k;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      k = (pick < 80) ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
      if (pick < 1) send_item(lpht_pkg::OP_CLEAR, k, $urandom);
      else send_item(lpht_pkg::op_t'($urandom_range(2)), k, $urandom);
    end
  endtask

  // Receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(12);
    join
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      mdl_state[i] = lpht_pkg::ST_UNUSED;
      mdl_key[i] = '0;
      mdl_value[i] = '0;
    end
    mdl_used = 0;
    mdl_size = 11'd1024;
    mdl_allow = 1'b1;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i] = key_pool[i] >> (8 * $urandom_range(7));
    end
    key_pool[0] = 64'h0;
    key_pool[1] = 64'hFF;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_small_table(11'd1, 1'b1, 30);
    test_small_table(11'd0, 1'b0, 20);
    test_small_table(11'd5, 1'b0, 60);
    test_small_table(11'd2047, 1'b1, 30);
    test_small_table(11'd1024, 1'b1, 10);
    test_backpressure();
    quiet_stall = 1'b1;
    test_random(150);
    quiet_stall = 1'b0;
    write_reg(lpht_pkg::CFG_TABLE_SIZE, 11'd13);
    test_random(300);
    write_reg(lpht_pkg::CFG_ALLOW_UPDATE, 11'd0);
    test_random(250);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
src/lpht_pkg.sv
src/lpht_ram.sv
src/linear_probe_hash_table_unit.sv
tb/tb_top.sv
